>>> sv/cp0rf_pkg.sv
// Package for the coprocessor-0 register file: register numbers, reset values and shared types.
`default_nettype none
package cp0rf_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned REG_NUM_W = 5;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [REG_NUM_W-1:0] REG_INDEX      = 5'd0;
  localparam logic [REG_NUM_W-1:0] REG_RANDOM     = 5'd1;
  localparam logic [REG_NUM_W-1:0] REG_ENTRY_LO0  = 5'd2;
  localparam logic [REG_NUM_W-1:0] REG_ENTRY_LO1  = 5'd3;
  localparam logic [REG_NUM_W-1:0] REG_CONTEXT    = 5'd4;
  localparam logic [REG_NUM_W-1:0] REG_PAGE_MASK  = 5'd5;
  localparam logic [REG_NUM_W-1:0] REG_WIRED      = 5'd6;
  localparam logic [REG_NUM_W-1:0] REG_UNUSED7    = 5'd7;
  localparam logic [REG_NUM_W-1:0] REG_BAD_VADDR  = 5'd8;
  localparam logic [REG_NUM_W-1:0] REG_ENTRY_HI   = 5'd10;
  localparam logic [REG_NUM_W-1:0] REG_STATUS     = 5'd12;
  localparam logic [REG_NUM_W-1:0] REG_CAUSE      = 5'd13;
  localparam logic [REG_NUM_W-1:0] REG_EPC        = 5'd14;
  localparam logic [REG_NUM_W-1:0] REG_PRID       = 5'd15;
  localparam logic [REG_NUM_W-1:0] REG_CONFIG     = 5'd16;
  localparam logic [REG_NUM_W-1:0] REG_XCONTEXT   = 5'd20;
  localparam logic [REG_NUM_W-1:0] REG_UNUSED21   = 5'd21;
  localparam logic [REG_NUM_W-1:0] REG_UNUSED22   = 5'd22;
  localparam logic [REG_NUM_W-1:0] REG_UNUSED23   = 5'd23;
  localparam logic [REG_NUM_W-1:0] REG_UNUSED24   = 5'd24;
  localparam logic [REG_NUM_W-1:0] REG_UNUSED25   = 5'd25;
  localparam logic [REG_NUM_W-1:0] REG_ERROR_EPC  = 5'd30;
  localparam logic [REG_NUM_W-1:0] REG_UNUSED31   = 5'd31;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LO_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_MASK_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_HI_MASK  = 2'd2;

  localparam logic [DATA_W-1:0] ENTRY_LO_MASK_RST  = 64'h0000_0000_3FFF_FFFF;
  localparam logic [DATA_W-1:0] PAGE_MASK_MASK_RST = 64'h0000_0000_01FF_E000;
  localparam logic [DATA_W-1:0] ENTRY_HI_MASK_RST  = 64'hC000_00FF_FFFF_E0FF;

  localparam logic [DATA_W-1:0] CONTEXT_BASE_MASK  = 64'hFFFF_FFFF_FF80_0000;
  localparam logic [DATA_W-1:0] XCONTEXT_BASE_MASK = 64'hFFFF_FFFE_0000_0000;

  localparam logic [CNT_W-1:0] RANDOM_RST = 6'd31;
  localparam logic [CNT_W-1:0] WIRED_RST  = 6'd0;
  localparam logic [CNT_W-1:0] RANDOM_TOP = 6'd31;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo_keep;
    logic [DATA_W-1:0] pm_keep;
    logic [DATA_W-1:0] hi_keep;
  } masks_t;

  typedef struct packed {
    mode_t                mode;
    logic [REG_NUM_W-1:0] reg_number;
    logic [DATA_W-1:0]    write_data;
  } access_t;

  typedef struct packed {
    logic              reg_we;
    logic [DATA_W-1:0] reg_wdata;
    logic [CNT_W-1:0]  random_nxt;
    logic [CNT_W-1:0]  wired_nxt;
    logic [DATA_W-1:0] read_data;
    logic              bad_register;
  } update_t;

  function automatic logic [DATA_W-1:0] reset_value(input logic [REG_NUM_W-1:0] n);
    logic [DATA_W-1:0] v;
    v = '0;
    unique case (n)
      REG_INDEX:     v = 64'd63;
      REG_BAD_VADDR: v = '1;
      REG_STATUS:    v = 64'h0000_0000_3400_0000;
      REG_CAUSE:     v = 64'h0000_0000_B000_107C;
      REG_EPC:       v = '1;
      REG_PRID:      v = 64'h0000_0000_0000_0B22;
      REG_CONFIG:    v = 64'h0000_0000_7006_E463;
      REG_ERROR_EPC: v = '1;
      default:       v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> sv/cp0rf_update.sv
// Decode, mask and merge logic for one register access.
`default_nettype none
module cp0rf_update (
  input  wire cp0rf_pkg::access_t                 acc,
  input  wire logic [cp0rf_pkg::DATA_W-1:0]       old_value,
  input  wire logic [cp0rf_pkg::CNT_W-1:0]        random_cur,
  input  wire logic [cp0rf_pkg::CNT_W-1:0]        wired_cur,
  input  wire cp0rf_pkg::masks_t                  masks,
  output cp0rf_pkg::update_t                      upd
);

  logic                             unused_num;
  logic                             fits32;
  logic [cp0rf_pkg::DATA_W-1:0]     widened;
  logic [cp0rf_pkg::DATA_W-1:0]     v;
  logic [cp0rf_pkg::CNT_W-1:0]      wired_new;
  logic [1:0]                       region;

  assign v       = acc.write_data;
  assign fits32  = (v[63:32] == 32'd0);
  assign widened = fits32 ? {{32{v[31]}}, v[31:0]} : v;
  assign region  = v[31] ? 2'b11 : 2'b00;
  assign wired_new = v[cp0rf_pkg::CNT_W-1:0];

  always_comb begin
    unused_num = 1'b0;
    case (acc.reg_number)
      cp0rf_pkg::REG_UNUSED7, cp0rf_pkg::REG_UNUSED21, cp0rf_pkg::REG_UNUSED22,
      cp0rf_pkg::REG_UNUSED23, cp0rf_pkg::REG_UNUSED24, cp0rf_pkg::REG_UNUSED25,
      cp0rf_pkg::REG_UNUSED31: unused_num = 1'b1;
      default: unused_num = 1'b0;
    endcase
  end

  always_comb begin
    upd              = '0;
    upd.random_nxt   = random_cur;
    upd.wired_nxt    = wired_cur;
    upd.bad_register = unused_num;
    if (!unused_num) begin
      if (acc.mode == cp0rf_pkg::MODE_READ) begin
        unique case (acc.reg_number)
          cp0rf_pkg::REG_RANDOM: upd.read_data = {58'd0, random_cur};
          cp0rf_pkg::REG_WIRED:  upd.read_data = {58'd0, wired_cur};
          default:               upd.read_data = old_value;
        endcase
      end else begin
        unique case (acc.reg_number)
          cp0rf_pkg::REG_RANDOM, cp0rf_pkg::REG_BAD_VADDR: upd.reg_we = 1'b0;
          cp0rf_pkg::REG_ENTRY_LO0, cp0rf_pkg::REG_ENTRY_LO1: begin
            upd.reg_we    = 1'b1;
            upd.reg_wdata = v & masks.lo_keep;
          end
          cp0rf_pkg::REG_CONTEXT: begin
            upd.reg_we    = 1'b1;
            upd.reg_wdata = (widened & cp0rf_pkg::CONTEXT_BASE_MASK) |
                            (old_value & ~cp0rf_pkg::CONTEXT_BASE_MASK);
          end
          cp0rf_pkg::REG_XCONTEXT: begin
            upd.reg_we    = 1'b1;
            upd.reg_wdata = (widened & cp0rf_pkg::XCONTEXT_BASE_MASK) |
                            (old_value & ~cp0rf_pkg::XCONTEXT_BASE_MASK);
          end
          cp0rf_pkg::REG_PAGE_MASK: begin
            upd.reg_we    = 1'b1;
            upd.reg_wdata = v & masks.pm_keep;
          end
          cp0rf_pkg::REG_WIRED: begin
            upd.wired_nxt = wired_new;
            // pull Random up to Wired; a Wired above 31 leaves Random alone
            if (!wired_new[cp0rf_pkg::CNT_W-1] && (random_cur < wired_new ||
                random_cur > cp0rf_pkg::RANDOM_TOP)) begin
              upd.random_nxt = wired_new;
            end
          end
          cp0rf_pkg::REG_ENTRY_HI: begin
            upd.reg_we    = 1'b1;
            upd.reg_wdata = fits32 ? {region, 30'd0, v[31:13], 5'd0, v[7:0]}
                                   : (v & masks.hi_keep);
          end
          default: begin
            upd.reg_we    = 1'b1;
            upd.reg_wdata = v;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/cp0_register_file_unit.sv
// Top level of the coprocessor-0 register file with stream channels and mask configuration.
//
// Usage:
//   Input channel (in_*): one transfer is one access. in_tuser is the access kind
//   (0 read, 1 write); in_tdata carries the register number and the write value.
//   Result channel (out_*): one transfer per access. out_tdata is the register
//   contents on a read and zero on a write; out_tuser flags an unimplemented number.
//   Configuration port (cfg_*): write the EntryLo, PageMask and wide EntryHi masks
//   while the block is idle; writes take effect on the next edge.
// Timing:
//   An access is captured in an input register, decoded and merged combinationally,
//   and lands in the result register. One access per cycle is sustained while
//   out_tready stays high; the register array updates as an access leaves the
//   input register, so each access sees every earlier write.
// Reset:
//   rst_n low clears both valid flags and loads the architectural reset values
//   into all registers, Random (31), Wired (0) and the three masks.
// Stall:
//   While out_tready is low a waiting result holds; the input register still takes
//   one more access, then in_tready drops until the result is taken.
`default_nettype none
module cp0_register_file_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // [4:0] reg_number, [68:5] write_data, [71:69] zero
  input  wire logic        in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] read_data
  output logic             out_tuser,  // [0] bad_register
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  logic [cp0rf_pkg::DATA_W-1:0] regs_r [cp0rf_pkg::NUM_REGS];
  logic [cp0rf_pkg::CNT_W-1:0]  random_r;
  logic [cp0rf_pkg::CNT_W-1:0]  wired_r;
  cp0rf_pkg::masks_t            masks_r;
  cp0rf_pkg::access_t           acc_r;
  logic                         acc_valid_r;
  logic [cp0rf_pkg::DATA_W-1:0] out_data_r;
  logic                         out_bad_r;
  logic                         out_valid_r;
  logic                         advance;
  cp0rf_pkg::update_t           upd;

  assign advance   = acc_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !acc_valid_r || advance;

  cp0rf_update u_update (
    .acc        (acc_r),
    .old_value  (regs_r[acc_r.reg_number]),
    .random_cur (random_r),
    .wired_cur  (wired_r),
    .masks      (masks_r),
    .upd        (upd)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
    end else if (in_tready) begin
      acc_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      acc_r.mode       <= cp0rf_pkg::mode_t'(in_tuser);
      acc_r.reg_number <= in_tdata[4:0];
      acc_r.write_data <= in_tdata[68:5];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_data_r <= upd.read_data;
      out_bad_r  <= upd.bad_register;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cp0rf_pkg::NUM_REGS; i++) begin
        regs_r[i] <= cp0rf_pkg::reset_value(i[cp0rf_pkg::REG_NUM_W-1:0]);
      end
      random_r <= cp0rf_pkg::RANDOM_RST;
      wired_r  <= cp0rf_pkg::WIRED_RST;
    end else if (advance) begin
      if (upd.reg_we) begin
        regs_r[acc_r.reg_number] <= upd.reg_wdata;
      end
      random_r <= upd.random_nxt;
      wired_r  <= upd.wired_nxt;
    end
  end

  // mask configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r.lo_keep <= cp0rf_pkg::ENTRY_LO_MASK_RST;
      masks_r.pm_keep <= cp0rf_pkg::PAGE_MASK_MASK_RST;
      masks_r.hi_keep <= cp0rf_pkg::ENTRY_HI_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cp0rf_pkg::CFG_ENTRY_LO_MASK:  masks_r.lo_keep <= cfg_wdata;
        cp0rf_pkg::CFG_PAGE_MASK_MASK: masks_r.pm_keep <= cfg_wdata;
        cp0rf_pkg::CFG_ENTRY_HI_MASK:  masks_r.hi_keep <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

`ifndef SYNTHESIS
  a_random_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !wired_r[cp0rf_pkg::CNT_W-1] |-> (random_r >= wired_r && random_r <= cp0rf_pkg::RANDOM_TOP))
    else $error("Random left its range above Wired");

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("unimplemented register returned nonzero data");

  a_bad_no_state_change: assert property (@(posedge clk) disable iff (!rst_n)
    advance && upd.bad_register |=> $stable(random_r) && $stable(wired_r))
    else $error("access to unimplemented register changed Random or Wired");
`endif

endmodule
`default_nettype wire
